### sv/ils_pkg.sv
// Package for the inverse-logistic selectivity block: widths, codes, the item
// side-band type and the constant functions that build the power-of-two factors.
// No dependencies.
package ils_pkg;

    localparam int VALUE_WIDTH_DEF    = 16;
    localparam int POW_TABLE_BITS_DEF = 10;
    localparam int PEAK_W             = 18;
    localparam int FRAC_W             = 16;
    localparam int TQ_W               = 19;
    localparam int UQ_W               = 21;
    localparam int WHOLE_W            = 5;
    localparam int Q30_W              = 30;
    localparam int PROD_W             = 31;
    localparam int DEN_W              = 32;
    localparam int NUM_W              = 50;
    localparam int LMUL_W             = 38;
    localparam int OUT_DATA_W         = 24;
    localparam int CFG_ADDR_W         = 2;
    localparam int LOG2_19_Q16        = 278392;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MIDPOINT,
        CFG_SPREAD,
        CFG_PEAK,
        CFG_CUTOFF
    } t_cfg_addr;

    typedef enum logic [1:0] {
        REGION_BELOW,
        REGION_PEAK,
        REGION_ZERO,
        REGION_CURVE
    } t_region;

    typedef struct packed {
        logic    positive;
        t_region region;
    } t_meta;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        logic [63:0] rem;
        int          k;
        rem  = x;
        root = 64'd0;
        bitv = 64'h4000_0000_0000_0000;
        for (k = 0; k < 32; k++) begin
            if (bitv > rem) begin
                bitv = bitv >> 2;
            end
        end
        for (k = 0; k < 32; k++) begin
            if (bitv != 64'd0) begin
                if (rem >= root + bitv) begin
                    rem  = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return root;
    endfunction

    // Factor 2^-(2^-j) in Q.30, each one the square root of the one before.
    function automatic logic [Q30_W-1:0] pow_factor(input int j);
        logic [63:0] f;
        int          k;
        f = 64'd1 << (Q30_W - 1);
        for (k = 1; k <= 14; k++) begin
            if (k <= j) begin
                f = isqrt64(f << Q30_W);
            end
        end
        return f[Q30_W-1:0];
    endfunction

endpackage

### sv/ils_div.sv
// Pipelined restoring divider, one quotient bit per register stage, with a
// side-band word carried alongside. Depends on nothing.
module ils_div #(
    parameter int QW = 19,
    parameter int DW = 16,
    parameter int SW = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [DW-1:0] i_div,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          s_valid [0:QW];
    logic [DW-1:0] s_rem   [0:QW];
    logic [QW-1:0] s_low   [0:QW];
    logic [DW-1:0] s_div   [0:QW];
    logic [SW-1:0] s_side  [0:QW];
    logic          s_ready [0:QW];

    assign s_valid[0] = i_valid;
    assign s_rem[0]   = i_rem;
    assign s_low[0]   = i_low;
    assign s_div[0]   = i_div;
    assign s_side[0]  = i_side;
    assign s_ready[QW] = i_ready;
    assign o_ready = s_ready[0];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          r_valid;
        logic [DW-1:0] r_rem;
        logic [QW-1:0] r_low;
        logic [DW-1:0] r_div;
        logic [SW-1:0] r_side;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW:0]   diff;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_low;

        assign trial = {s_rem[k], s_low[k][QW-1]};
        assign ge    = trial >= {1'b0, s_div[k]};
        assign diff  = trial - {1'b0, s_div[k]};
        assign n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
        assign n_low = {s_low[k][QW-2:0], ge};
        assign s_ready[k] = !r_valid || s_ready[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (s_ready[k]) begin
                r_valid <= s_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (s_ready[k]) begin
                r_rem  <= n_rem;
                r_low  <= n_low;
                r_div  <= s_div[k];
                r_side <= s_side[k];
            end
        end

        assign s_valid[k+1] = r_valid;
        assign s_rem[k+1]   = r_rem;
        assign s_low[k+1]   = r_low;
        assign s_div[k+1]   = r_div;
        assign s_side[k+1]  = r_side;
    end

    assign o_valid = s_valid[QW];
    assign o_quo   = s_low[QW];
    assign o_side  = s_side[QW];

endmodule

### sv/ils_pow.sv
// Pipelined 2^-u in Q.30: one stage per each of the top PTB fraction bits multiplies in a constant
// factor, a last stage applies the rounded integer shift. Depends on ils_pkg.
module ils_pow #(
    parameter int PTB = 10,
    parameter int SW  = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ils_pkg::UQ_W-1:0]   i_u,
    input  logic [SW-1:0]         i_side,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [ils_pkg::PROD_W-1:0] o_g,
    output logic [SW-1:0]         o_side
);
    import ils_pkg::*;

    localparam int MUL_W = PROD_W + Q30_W;

    logic               s_valid [0:PTB];
    logic [PROD_W-1:0]  s_prod  [0:PTB];
    logic [WHOLE_W-1:0] s_whole [0:PTB];
    logic [PTB-1:0]     s_idx   [0:PTB];
    logic [SW-1:0]      s_side  [0:PTB];
    logic               s_ready [0:PTB+1];

    logic               r_valid;
    logic [PROD_W-1:0]  r_g;
    logic [SW-1:0]      r_side;
    logic [PROD_W-1:0]  shifted;
    logic [PROD_W:0]    bumped;
    logic [PROD_W-1:0]  n_g;

    assign s_valid[0] = i_valid;
    assign s_prod[0]  = PROD_W'(64'd1 << Q30_W);
    assign s_whole[0] = i_u[FRAC_W +: WHOLE_W];
    assign s_idx[0]   = i_u[FRAC_W-1 -: PTB];
    assign s_side[0]  = i_side;
    assign o_ready    = s_ready[0];

    for (genvar k = 0; k < PTB; k++) begin : g_stage
        localparam logic [Q30_W-1:0] FACT = pow_factor(k + 1);
        logic               r_valid_k;
        logic [PROD_W-1:0]  r_prod;
        logic [WHOLE_W-1:0] r_whole;
        logic [PTB-1:0]     r_idx;
        logic [SW-1:0]      r_side_k;
        logic [MUL_W-1:0]   mul;
        logic [MUL_W-1:0]   rnd;
        logic [PROD_W-1:0]  n_prod;

        assign mul    = MUL_W'(s_prod[k]) * MUL_W'(FACT);
        assign rnd    = mul + (MUL_W'(1) << (Q30_W - 1));
        assign n_prod = s_idx[k][PTB-1-k] ? rnd[Q30_W +: PROD_W] : s_prod[k];
        assign s_ready[k] = !r_valid_k || s_ready[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid_k <= 1'b0;
            end else if (s_ready[k]) begin
                r_valid_k <= s_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (s_ready[k]) begin
                r_prod   <= n_prod;
                r_whole  <= s_whole[k];
                r_idx    <= s_idx[k];
                r_side_k <= s_side[k];
            end
        end

        assign s_valid[k+1] = r_valid_k;
        assign s_prod[k+1]  = r_prod;
        assign s_whole[k+1] = r_whole;
        assign s_idx[k+1]   = r_idx;
        assign s_side[k+1]  = r_side_k;
    end

    always_comb begin
        shifted = s_prod[PTB] >> (s_whole[PTB] - WHOLE_W'(1));
        bumped  = {1'b0, shifted} + (PROD_W+1)'(1);
        if (s_whole[PTB] == '1) begin
            n_g = '0;
        end else if (s_whole[PTB] == '0) begin
            n_g = s_prod[PTB];
        end else begin
            n_g = bumped[PROD_W:1];
        end
    end

    assign s_ready[PTB]   = !r_valid || s_ready[PTB+1];
    assign s_ready[PTB+1] = i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_ready[PTB]) begin
            r_valid <= s_valid[PTB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready[PTB]) begin
            r_g    <= n_g;
            r_side <= s_side[PTB];
        end
    end

    assign o_valid = r_valid;
    assign o_g     = r_g;
    assign o_side  = r_side;

endmodule

### sv/inverse_logistic_selectivity.sv
// Top level of the inverse-logistic selectivity evaluator: configuration
// registers, front stage, scaling stages and output register.
// Depends on ils_pkg, ils_div and ils_pow.
//
//  Channel  | Direction | Contents
//  s_axis   | in        | tdata: sample_value
//  m_axis   | out       | tdata: selectivity; tuser: region
//  i_cfg_*  | in        | register writes: midpoint, spread, peak, cutoff
//
// One request enters per cycle unless a stall holds the pipeline; each result passes through
// the front stage, the two bit-per-stage dividers, the factor stages and the output register.
// Reset clears all valid bits and loads the register defaults.
// Every stage holds its item while the next one is full, so stalls lose nothing.
module inverse_logistic_selectivity #(
    parameter int VALUE_WIDTH    = ils_pkg::VALUE_WIDTH_DEF,
    parameter int POW_TABLE_BITS = ils_pkg::POW_TABLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Fields from bit 0: sample_value.
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Fields from bit 0: selectivity.
    output logic [ils_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // Fields from bit 0: region.
    output logic [1:0]                            m_axis_tuser,
    input  logic                                  i_cfg_wen,
    input  logic [ils_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [((VALUE_WIDTH > ils_pkg::PEAK_W) ?
                   VALUE_WIDTH : ils_pkg::PEAK_W)-1:0] i_cfg_wdata
);
    import ils_pkg::*;

    localparam int VW     = VALUE_WIDTH;
    localparam int LIM_W  = VW + 3;
    localparam int N1_W   = VW + TQ_W;
    localparam int META_W = $bits(t_meta);

    logic [VW-1:0]     r_midpoint;
    logic [VW-1:0]     r_spread;
    logic [PEAK_W-1:0] r_peak;
    logic [VW-1:0]     r_cutoff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_midpoint <= '0;
            r_spread   <= VW'(32'd256);
            r_peak     <= PEAK_W'(32'd65536);
            r_cutoff   <= '0;
        end else if (i_cfg_wen) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_MIDPOINT: r_midpoint <= i_cfg_wdata[VW-1:0];
                CFG_SPREAD:   r_spread   <= i_cfg_wdata[VW-1:0];
                CFG_PEAK:     r_peak     <= i_cfg_wdata[PEAK_W-1:0];
                CFG_CUTOFF:   r_cutoff   <= i_cfg_wdata[VW-1:0];
                default:      r_midpoint <= r_midpoint;
            endcase
        end
    end

    // Front stage.
    logic          r_f_valid;
    logic [VW-1:0] r_f_value;
    logic          f_ready;
    logic          d1_ready;

    assign f_ready       = !r_f_valid || d1_ready;
    assign s_axis_tready = f_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (f_ready) begin
            r_f_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_ready) begin
            r_f_value <= s_axis_tdata[VW-1:0];
        end
    end

    logic [VW-1:0]    sp;
    logic [LIM_W-1:0] lim;
    logic             positive;
    logic [VW-1:0]    mag;
    t_meta            f_meta;
    logic [N1_W-1:0]  n1;

    always_comb begin
        sp       = (r_spread == '0) ? VW'(1) : r_spread;
        lim      = LIM_W'({sp, 2'b00}) + LIM_W'(sp);
        positive = r_midpoint >= r_f_value;
        mag      = positive ? (r_midpoint - r_f_value) : (r_f_value - r_midpoint);
        f_meta.positive = positive;
        if (r_f_value < r_cutoff) begin
            f_meta.region = REGION_BELOW;
        end else if (LIM_W'(mag) > lim) begin
            f_meta.region = positive ? REGION_PEAK : REGION_ZERO;
        end else begin
            f_meta.region = REGION_CURVE;
        end
        n1 = (N1_W'(mag) << FRAC_W) + N1_W'(sp >> 1);
    end

    logic              d1_valid;
    logic [TQ_W-1:0]   d1_quo;
    logic [META_W-1:0] d1_side;
    logic              l_ready;

    ils_div #(
        .QW (TQ_W),
        .DW (VW),
        .SW (META_W)
    ) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_valid),
        .o_ready (d1_ready),
        .i_rem   (n1[N1_W-1:TQ_W]),
        .i_low   (n1[TQ_W-1:0]),
        .i_div   (sp),
        .i_side  (f_meta),
        .o_valid (d1_valid),
        .i_ready (l_ready),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // Scale by log2(19).
    logic              r_l_valid;
    logic [UQ_W-1:0]   r_l_u;
    logic [META_W-1:0] r_l_meta;
    logic              p_ready;
    logic [LMUL_W-1:0] lmul;

    assign lmul    = LMUL_W'(d1_quo) * LMUL_W'(LOG2_19_Q16)
                   + (LMUL_W'(1) << (FRAC_W - 1));
    assign l_ready = !r_l_valid || p_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_valid <= 1'b0;
        end else if (l_ready) begin
            r_l_valid <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_ready) begin
            r_l_u    <= lmul[FRAC_W +: UQ_W];
            r_l_meta <= d1_side;
        end
    end

    logic              p_valid;
    logic [PROD_W-1:0] p_g;
    logic [META_W-1:0] p_side;
    logic              n_ready;

    ils_pow #(
        .PTB (POW_TABLE_BITS),
        .SW  (META_W)
    ) u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_l_valid),
        .o_ready (p_ready),
        .i_u     (r_l_u),
        .i_side  (r_l_meta),
        .o_valid (p_valid),
        .i_ready (n_ready),
        .o_g     (p_g),
        .o_side  (p_side)
    );

    // Numerator and denominator of the final ratio.
    logic              r_n_valid;
    logic [DEN_W-1:0]  r_n_rem;
    logic [PEAK_W-1:0] r_n_low;
    logic [DEN_W-1:0]  r_n_den;
    logic [META_W-1:0] r_n_meta;
    logic              d2_ready;
    t_meta             p_meta;
    logic [DEN_W-1:0]  den;
    logic [NUM_W-1:0]  num;

    always_comb begin
        p_meta = t_meta'(p_side);
        den    = (DEN_W'(1) << Q30_W) + DEN_W'(p_g);
        if (p_meta.positive) begin
            num = NUM_W'(r_peak) << Q30_W;
        end else begin
            num = NUM_W'(r_peak) * NUM_W'(p_g);
        end
        num = num + NUM_W'(den >> 1);
    end

    assign n_ready = !r_n_valid || d2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else if (n_ready) begin
            r_n_valid <= p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_ready) begin
            r_n_rem  <= num[PEAK_W +: DEN_W];
            r_n_low  <= num[PEAK_W-1:0];
            r_n_den  <= den;
            r_n_meta <= p_side;
        end
    end

    logic              d2_valid;
    logic [PEAK_W-1:0] d2_quo;
    logic [META_W-1:0] d2_side;
    logic              o_ready_stage;

    ils_div #(
        .QW (PEAK_W),
        .DW (DEN_W),
        .SW (META_W)
    ) u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_n_valid),
        .o_ready (d2_ready),
        .i_rem   (r_n_rem),
        .i_low   (r_n_low),
        .i_div   (r_n_den),
        .i_side  (r_n_meta),
        .o_valid (d2_valid),
        .i_ready (o_ready_stage),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    // Output register.
    logic              r_o_valid;
    logic [PEAK_W-1:0] r_o_sel;
    t_region           r_o_region;
    t_meta             d2_meta;
    logic [PEAK_W-1:0] n_sel;

    always_comb begin
        d2_meta = t_meta'(d2_side);
        case (d2_meta.region)
            REGION_CURVE: n_sel = (d2_quo > r_peak) ? r_peak : d2_quo;
            REGION_PEAK:  n_sel = r_peak;
            default:      n_sel = '0;
        endcase
    end

    assign o_ready_stage = !r_o_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_ready_stage) begin
            r_o_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready_stage) begin
            r_o_sel    <= n_sel;
            r_o_region <= d2_meta.region;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_o_sel);
    assign m_axis_tuser  = r_o_region;

endmodule
